>>> hdl/rcpwm_pkg.sv
`timescale 1ns / 1ps

package rcpwm_pkg;

  localparam int unsigned NumChannels = 6;
  localparam int unsigned TimerBits   = 16;
  localparam int unsigned ChanBits    = 3;
  localparam int unsigned MaskBits    = 6;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CfgMaxPulse      = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgTimeoutPolls  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgFailsafeLow   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgFailsafeCtr   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgCenterMask    = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgWatchedChan   = 3'd5;

  localparam logic [TimerBits-1:0] RstMaxPulse     = 16'd6000;
  localparam logic [15:0]          RstTimeoutPolls = 16'd50;
  localparam logic [TimerBits-1:0] RstFailsafeLow  = 16'd2592;
  localparam logic [TimerBits-1:0] RstFailsafeCtr  = 16'd3600;
  localparam logic [MaskBits-1:0]  RstCenterMask   = 6'd14;
  localparam logic [ChanBits-1:0]  RstWatchedChan  = 3'd1;

  typedef logic [TimerBits-1:0] tick_t;

  typedef struct packed {
    logic                              edge_falling;
    logic [ChanBits-1:0]               event_channel;
    tick_t                             period_ticks;
    tick_t                             pulse_ticks;
    logic                              pulse_accepted;
    logic                              link_ok;
    logic [NumChannels-1:0][TimerBits-1:0] held;
  } result_t;

endpackage

>>> hdl/rc_pwm_capture_decoder.sv
`timescale 1ns / 1ps
// a request's result is registered before it is shown at the outputs
// throughput: one request per cycle while the skid stage is empty; channel state updates in a single pass
// an output register plus a skid stage let a request enter while a result waits
// reset: asynchronous active low, clears channel state, watchdog and output valids,
// and loads the configuration registers with their default values

module rc_pwm_capture_decoder
  import rcpwm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic [ChanBits-1:0]    channel_i,
  input  logic [TimerBits-1:0]   capture_time_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   edge_falling_o,
  output logic [ChanBits-1:0]    event_channel_o,
  output logic [TimerBits-1:0]   period_ticks_o,
  output logic [TimerBits-1:0]   pulse_ticks_o,
  output logic                   pulse_accepted_o,
  output logic                   link_ok_o,
  output logic [TimerBits-1:0]   held_width_0_o,
  output logic [TimerBits-1:0]   held_width_1_o,
  output logic [TimerBits-1:0]   held_width_2_o,
  output logic [TimerBits-1:0]   held_width_3_o,
  output logic [TimerBits-1:0]   held_width_4_o,
  output logic [TimerBits-1:0]   held_width_5_o
);

  tick_t               max_pulse_q;
  logic [15:0]         timeout_q;
  tick_t               fs_low_q;
  tick_t               fs_ctr_q;
  logic [MaskBits-1:0] ctr_mask_q;
  logic [ChanBits-1:0] watched_q;

  logic [NumChannels-1:0] ef_q, ef_d;
  tick_t last_rise_q [NumChannels];
  tick_t last_rise_d [NumChannels];
  tick_t last_fall_q [NumChannels];
  tick_t last_fall_d [NumChannels];
  logic [NumChannels-1:0][TimerBits-1:0] held_q, held_d;
  tick_t       prior_fall_q, prior_fall_d;
  logic [15:0] idle_cnt_q, idle_cnt_d;

  result_t out_q, skid_q, res_d;
  logic    out_valid_q, skid_valid_q;

  logic  in_acc, pop, hit, ef_sel, changed, timed_out;
  tick_t rise_sel, diff, fall_w;

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pulse_q <= RstMaxPulse;
      timeout_q   <= RstTimeoutPolls;
      fs_low_q    <= RstFailsafeLow;
      fs_ctr_q    <= RstFailsafeCtr;
      ctr_mask_q  <= RstCenterMask;
      watched_q   <= RstWatchedChan;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMaxPulse:     max_pulse_q <= cfg_data_i[TimerBits-1:0];
        CfgTimeoutPolls: timeout_q   <= cfg_data_i[15:0];
        CfgFailsafeLow:  fs_low_q    <= cfg_data_i[TimerBits-1:0];
        CfgFailsafeCtr:  fs_ctr_q    <= cfg_data_i[TimerBits-1:0];
        CfgCenterMask:   ctr_mask_q  <= cfg_data_i[MaskBits-1:0];
        CfgWatchedChan:  watched_q   <= cfg_data_i[ChanBits-1:0];
        default: ;
      endcase
    end
  end

  // single-pass update of channel state and watchdog
  always_comb begin
    hit      = !func_i && (32'(channel_i) < NumChannels);
    rise_sel = '0;
    ef_sel   = 1'b0;
    fall_w   = '0;
    for (int c = 0; c < NumChannels; c++) begin
      if (32'(channel_i) == c) begin
        rise_sel = last_rise_q[c];
        ef_sel   = ef_q[c];
      end
      if (32'(watched_q) == c) begin
        fall_w = last_fall_q[c];
      end
    end
    diff      = capture_time_i - rise_sel;
    changed   = fall_w != prior_fall_q;
    timed_out = !changed && !(idle_cnt_q < timeout_q);

    ef_d         = ef_q;
    held_d       = held_q;
    prior_fall_d = prior_fall_q;
    idle_cnt_d   = idle_cnt_q;
    for (int c = 0; c < NumChannels; c++) begin
      last_rise_d[c] = last_rise_q[c];
      last_fall_d[c] = last_fall_q[c];
    end

    res_d                = '0;
    res_d.event_channel  = func_i ? '0 : channel_i;

    if (func_i) begin
      prior_fall_d  = fall_w;
      res_d.link_ok = !timed_out;
      if (changed) begin
        idle_cnt_d = '0;
      end else if (!timed_out) begin
        idle_cnt_d = idle_cnt_q + 16'd1;
      end else begin
        for (int c = 0; c < NumChannels; c++) begin
          if (c < MaskBits && ctr_mask_q[c % MaskBits]) begin
            held_d[c] = fs_ctr_q;
          end else begin
            held_d[c] = fs_low_q;
          end
        end
      end
    end else if (hit) begin
      res_d.edge_falling = ef_sel;
      if (!ef_sel) begin
        res_d.period_ticks = diff;
      end else begin
        res_d.pulse_ticks    = diff;
        res_d.pulse_accepted = diff <= max_pulse_q;
      end
      for (int c = 0; c < NumChannels; c++) begin
        if (32'(channel_i) == c) begin
          ef_d[c] = !ef_q[c];
          if (!ef_sel) begin
            last_rise_d[c] = capture_time_i;
          end else begin
            last_fall_d[c] = capture_time_i;
            if (diff <= max_pulse_q) begin
              held_d[c] = diff;
            end
          end
        end
      end
    end
    res_d.held = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ef_q         <= '0;
      held_q       <= '0;
      prior_fall_q <= '0;
      idle_cnt_q   <= '0;
      for (int c = 0; c < NumChannels; c++) begin
        last_rise_q[c] <= '0;
        last_fall_q[c] <= '0;
      end
    end else if (in_acc) begin
      ef_q         <= ef_d;
      held_q       <= held_d;
      prior_fall_q <= prior_fall_d;
      idle_cnt_q   <= idle_cnt_d;
      for (int c = 0; c < NumChannels; c++) begin
        last_rise_q[c] <= last_rise_d[c];
        last_fall_q[c] <= last_fall_d[c];
      end
    end
  end

  // output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (!out_valid_q || pop) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign edge_falling_o   = out_q.edge_falling;
  assign event_channel_o  = out_q.event_channel;
  assign period_ticks_o   = out_q.period_ticks;
  assign pulse_ticks_o    = out_q.pulse_ticks;
  assign pulse_accepted_o = out_q.pulse_accepted;
  assign link_ok_o        = out_q.link_ok;
  assign held_width_0_o   = out_q.held[0];
  assign held_width_1_o   = out_q.held[1];
  assign held_width_2_o   = out_q.held[2];
  assign held_width_3_o   = out_q.held[3];
  assign held_width_4_o   = out_q.held[4];
  assign held_width_5_o   = out_q.held[5];

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("pending result vanished without being taken");

  a_edge_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !func_i && channel_i == '0 |=> ef_q[0] != $past(ef_q[0]))
    else $error("edge phase of channel 0 did not toggle on its capture");

  a_accept_falling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pulse_accepted |-> out_q.edge_falling && out_q.period_ticks == '0)
    else $error("accepted pulse reported on a non-falling result");

  a_poll_resets_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func_i && changed |=> idle_cnt_q == '0)
    else $error("idle poll count not cleared after a fresh watched fall");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

class capture_tracker;
  logic [15:0] max_pulse;
  logic [15:0] timeout_polls;
  logic [15:0] fs_low;
  logic [15:0] fs_center;
  logic [5:0]  center_mask;
  logic [2:0]  watched;
  bit          fall_next [rcpwm_pkg::NumChannels];
  logic [15:0] rise_at [rcpwm_pkg::NumChannels];
  logic [15:0] fall_at [rcpwm_pkg::NumChannels];
  logic [15:0] held [rcpwm_pkg::NumChannels];
  logic [15:0] prior_fall;
  logic [15:0] idle_polls;
  rcpwm_pkg::result_t pending_results[$];
  int errors;
  int checked;
  int held_pulses;
  int failsafe_polls;

  function new();
    int c;
    max_pulse     = rcpwm_pkg::RstMaxPulse;
    timeout_polls = rcpwm_pkg::RstTimeoutPolls;
    fs_low        = rcpwm_pkg::RstFailsafeLow;
    fs_center     = rcpwm_pkg::RstFailsafeCtr;
    center_mask   = rcpwm_pkg::RstCenterMask;
    watched       = rcpwm_pkg::RstWatchedChan;
    for (c = 0; c < rcpwm_pkg::NumChannels; c++) begin
      fall_next[c] = 1'b0;
      rise_at[c]   = '0;
      fall_at[c]   = '0;
      held[c]      = '0;
    end
    prior_fall     = '0;
    idle_polls     = '0;
    errors         = 0;
    checked        = 0;
    held_pulses    = 0;
    failsafe_polls = 0;
  endfunction

  function void write_register(logic [2:0] idx, logic [15:0] data);
    case (idx)
      rcpwm_pkg::CfgMaxPulse:     max_pulse = data;
      rcpwm_pkg::CfgTimeoutPolls: timeout_polls = data;
      rcpwm_pkg::CfgFailsafeLow:  fs_low = data;
      rcpwm_pkg::CfgFailsafeCtr:  fs_center = data;
      rcpwm_pkg::CfgCenterMask:   center_mask = data[5:0];
      rcpwm_pkg::CfgWatchedChan:  watched = data[2:0];
      default: ;
    endcase
  endfunction

  function bit run_watchdog();
    logic [15:0] fall;
    bit ok;
    int c;
    fall = '0;
    if (watched < rcpwm_pkg::NumChannels) fall = fall_at[watched];
    if (fall != prior_fall) begin
      idle_polls = '0;
      ok = 1'b1;
    end else if (idle_polls < timeout_polls) begin
      idle_polls = idle_polls + 16'd1;
      ok = 1'b1;
    end else begin
      for (c = 0; c < rcpwm_pkg::NumChannels; c++) begin
        held[c] = center_mask[c] ? fs_center : fs_low;
      end
      failsafe_polls++;
      ok = 1'b0;
    end
    prior_fall = fall;
    return ok;
  endfunction

  function void note_request(logic f, logic [2:0] ch, logic [15:0] t);
    rcpwm_pkg::result_t r;
    int c;
    r = '0;
    if (f) begin
      r.link_ok = run_watchdog();
    end else begin
      r.event_channel = ch;
      if (ch < rcpwm_pkg::NumChannels) begin
        if (!fall_next[ch]) begin
          r.period_ticks = t - rise_at[ch];
          rise_at[ch] = t;
        end else begin
          r.edge_falling = 1'b1;
          fall_at[ch] = t;
          r.pulse_ticks = t - rise_at[ch];
          if (r.pulse_ticks <= max_pulse) begin
            held[ch] = r.pulse_ticks;
            r.pulse_accepted = 1'b1;
            held_pulses++;
          end
        end
        fall_next[ch] = !fall_next[ch];
      end
    end
    for (c = 0; c < rcpwm_pkg::NumChannels; c++) r.held[c] = held[c];
    pending_results.push_back(r);
  endfunction

  function bit same(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function void check_result(rcpwm_pkg::result_t got);
    rcpwm_pkg::result_t want;
    bit ok;
    int c;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing pending, got %0h", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    checked++;
    ok = 1'b1;
    ok &= same("edge_falling", 16'(want.edge_falling), 16'(got.edge_falling));
    ok &= same("event_channel", 16'(want.event_channel), 16'(got.event_channel));
    ok &= same("period_ticks", want.period_ticks, got.period_ticks);
    ok &= same("pulse_ticks", want.pulse_ticks, got.pulse_ticks);
    ok &= same("pulse_accepted", 16'(want.pulse_accepted), 16'(got.pulse_accepted));
    ok &= same("link_ok", 16'(want.link_ok), 16'(got.link_ok));
    for (c = 0; c < rcpwm_pkg::NumChannels; c++) begin
      ok &= same($sformatf("held_width_%0d", c), want.held[c], got.held[c]);
    end
    if (!ok) errors++;
  endfunction
endclass

module tb_top;
  import rcpwm_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   func_i = 1'b0;
  logic [ChanBits-1:0]    channel_i = '0;
  logic [TimerBits-1:0]   capture_time_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   edge_falling_o;
  logic [ChanBits-1:0]    event_channel_o;
  logic [TimerBits-1:0]   period_ticks_o;
  logic [TimerBits-1:0]   pulse_ticks_o;
  logic                   pulse_accepted_o;
  logic                   link_ok_o;
  logic [TimerBits-1:0]   held_width_0_o;
  logic [TimerBits-1:0]   held_width_1_o;
  logic [TimerBits-1:0]   held_width_2_o;
  logic [TimerBits-1:0]   held_width_3_o;
  logic [TimerBits-1:0]   held_width_4_o;
  logic [TimerBits-1:0]   held_width_5_o;

  capture_tracker tracker = new();
  bit             idle_on = 1'b1;
  int             stall_left = 0;
  int             settings_used = 0;
  logic [15:0]    gen_clock = '0;
  result_t        seen;

  rc_pwm_capture_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .channel_i        (channel_i),
    .capture_time_i   (capture_time_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .edge_falling_o   (edge_falling_o),
    .event_channel_o  (event_channel_o),
    .period_ticks_o   (period_ticks_o),
    .pulse_ticks_o    (pulse_ticks_o),
    .pulse_accepted_o (pulse_accepted_o),
    .link_ok_o        (link_ok_o),
    .held_width_0_o   (held_width_0_o),
    .held_width_1_o   (held_width_1_o),
    .held_width_2_o   (held_width_2_o),
    .held_width_3_o   (held_width_3_o),
    .held_width_4_o   (held_width_4_o),
    .held_width_5_o   (held_width_5_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 30) begin
      stall_left <= gap_length() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.edge_falling   = edge_falling_o;
      seen.event_channel  = event_channel_o;
      seen.period_ticks   = period_ticks_o;
      seen.pulse_ticks    = pulse_ticks_o;
      seen.pulse_accepted = pulse_accepted_o;
      seen.link_ok        = link_ok_o;
      seen.held[0]        = held_width_0_o;
      seen.held[1]        = held_width_1_o;
      seen.held[2]        = held_width_2_o;
      seen.held[3]        = held_width_3_o;
      seen.held[4]        = held_width_4_o;
      seen.held[5]        = held_width_5_o;
      tracker.check_result(seen);
    end
  end

  task automatic send_request(input logic f, input logic [ChanBits-1:0] c,
                              input logic [TimerBits-1:0] t);
    int gap;
    in_valid_i <= 1'b1;
    func_i <= f;
    channel_i <= c;
    capture_time_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(f, c, t);
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 35) gap = gap_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_capture(input logic [ChanBits-1:0] c, input logic [TimerBits-1:0] t);
    send_request(1'b0, c, t);
  endtask

  task automatic send_poll();
    send_request(1'b1, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_register(idx, data);
  endtask

  task automatic apply_setting(input logic [15:0] mp, input logic [15:0] to,
                               input logic [15:0] fl, input logic [15:0] fc,
                               input logic [5:0] mask, input logic [2:0] wch);
    drain();
    write_reg(CfgMaxPulse, mp);
    write_reg(CfgTimeoutPolls, to);
    write_reg(CfgFailsafeLow, fl);
    write_reg(CfgFailsafeCtr, fc);
    write_reg(CfgCenterMask, {10'd0, mask});
    write_reg(CfgWatchedChan, {13'd0, wch});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  task automatic random_capture();
    logic [ChanBits-1:0]  c;
    logic [TimerBits-1:0] w;
    logic [TimerBits-1:0] lim;
    int                   pick;
    c = 3'($urandom_range(0, NumChannels - 1));
    lim = tracker.max_pulse;
    if (tracker.fall_next[c]) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) w = 16'($urandom_range(0, lim));
      else if (pick < 60) w = lim + 16'($urandom_range(0, 4)) - 16'd2;
      else if (pick < 80) w = 16'($urandom_range(2000, 4500));
      else w = 16'($urandom_range(0, 65535));
      send_capture(c, tracker.rise_at[c] + w);
    end else begin
      gen_clock = gen_clock + 16'($urandom_range(1, 40000));
      send_capture(c, gen_clock);
    end
  endtask

  task automatic random_phase(input int count);
    int items;
    int n;
    int pick;
    items = 0;
    while (items < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        n = $urandom_range(1, 10);
        repeat (n) send_poll();
        items += n;
      end else if (pick < 30) begin
        send_capture(3'($urandom_range(NumChannels, 7)), 16'($urandom_range(0, 65535)));
        items++;
      end else if (pick < 40) begin
        send_capture(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
        items++;
      end else begin
        random_capture();
        items++;
      end
    end
  endtask

  initial begin
    int p;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default settings: wrap, limit and ignored channels
    send_capture(3'd0, 16'h0000);
    send_capture(3'd0, 16'd100);
    send_capture(3'd0, 16'hFFFF);
    send_capture(3'd0, 16'h0004);
    send_capture(3'd1, 16'd1000);
    send_capture(3'd1, 16'd7000);
    send_capture(3'd2, 16'h8000);
    send_capture(3'd2, 16'h8000 + 16'd6001);
    send_capture(3'd6, 16'h5555);
    send_capture(3'd7, 16'hAAAA);
    send_poll();
    send_poll();
    send_capture(3'd5, 16'hFFFF);
    send_capture(3'd5, 16'hFFFF);

    // zero timeout and zero width limit
    apply_setting(16'd0, 16'd0, 16'hFFFF, 16'd0, 6'h2A, 3'd1);
    send_poll();
    send_capture(3'd3, 16'd10);
    send_capture(3'd3, 16'd10);
    send_capture(3'd4, 16'd0);
    send_capture(3'd4, 16'd1);
    send_poll();

    // unlimited width, watched channel out of range
    apply_setting(16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 6'h3F, 3'd7);
    send_capture(3'd4, 16'h1234);
    send_capture(3'd4, 16'h1233);
    send_poll();
    send_poll();
    send_poll();

    for (p = 0; p < 8; p++) begin
      idle_on = (p != 3);
      case (p)
        0: apply_setting(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 6'h3F, 3'd0);
        1: apply_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 6'h00, 3'd5);
        2: apply_setting(16'($urandom_range(1500, 9000)), 16'($urandom_range(0, 6)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         6'($urandom_range(0, 63)), 3'd6);
        default: apply_setting(16'($urandom_range(1500, 9000)), 16'($urandom_range(0, 6)),
                               16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)),
                               6'($urandom_range(0, 63)),
                               3'($urandom_range(0, NumChannels - 1)));
      endcase
      random_phase(100);
    end
    idle_on = 1'b1;

    drain();
    if (tracker.pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.pending_results.size());
      tracker.errors++;
    end
    $display("summary: %0d results checked under %0d register settings", tracker.checked,
             settings_used);
    $display("summary: %0d widths held, %0d failsafe polls, %0d mismatching results",
             tracker.held_pulses, tracker.failsafe_polls, tracker.errors);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hdl/rcpwm_pkg.sv
hdl/rc_pwm_capture_decoder.sv
test/tb_top.sv
